// ===== hdl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared types and constants for the probable-prime tester
// ----------------------------------------------------------------------------
package mrpt_pkg;

   localparam int unsigned CAND_WIDTH  = 31;
   localparam int unsigned ROUND_WIDTH = 8;
   localparam int unsigned SEED_WIDTH  = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [SEED_WIDTH-1:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [ROUND_WIDTH-1:0] ROUND_COUNT_RESET = 8'd50;
   localparam logic [SEED_WIDTH-1:0]  WITNESS_SEED_RESET = 32'd1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROUND_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WITNESS_SEED = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_DRAW,
      ST_REDUCE,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_CHECK,
      ST_SQUARE,
      ST_SQUARE_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_MULMOD,
      OP_MOD
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } mod_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

// ===== hdl/mrpt_channel_if.sv =====
// ----------------------------------------------------------------------------
// mrpt_channel_if
// valid/ready channel interfaces for requests, responses and csr writes
// ----------------------------------------------------------------------------
interface mrpt_req_if;
   logic                            valid;
   logic                            ready;
   logic [mrpt_pkg::CAND_WIDTH-1:0] candidate;
   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;
   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

interface mrpt_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [mrpt_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [mrpt_pkg::SEED_WIDTH-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/miller_rabin_primality_test.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_primality_test
// probable-prime tester, sequencer around one shared modular unit
// ----------------------------------------------------------------------------
// small or even candidates go from idle straight to done; others run
//   the witness rounds through the modular unit
// throughput: one transaction at a time, set by the bit-serial modular unit
// reset: synchronous, round_count 50, witness lfsr 1, no transaction pending
module miller_rabin_primality_test #(
   parameter int unsigned NUMBER_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   mrpt_req_if.sink   req,
   mrpt_rsp_if.source rsp,
   mrpt_csr_if.sink   csr
);

   localparam int unsigned W = NUMBER_WIDTH;

   mrpt_pkg::state_type      state_ff, state_in;
   mrpt_pkg::mod_cmd_type    cmd;
   mrpt_pkg::mod_status_type status;

   logic [W-1:0] n_ff, n_in, d_ff, d_in, e_ff, e_in, base_ff, base_in;
   logic [W-1:0] acc_ff, acc_in, sq_e_ff, sq_e_in;
   logic [W-1:0] op_a, op_b, op_m, unit_result, nm1;
   logic [mrpt_pkg::ROUND_WIDTH-1:0] round_count_ff, rounds_ff, rounds_in;
   logic         prime_ff, prime_in, rsp_valid_ff, rsp_valid_in;
   logic         lfsr_step, csr_seed;
   logic         pow_mul_ff, pow_mul_in;
   logic [mrpt_pkg::SEED_WIDTH-1:0] lfsr_value;
   logic [W-1:0] cand_ext;

   assign cand_ext = W'(req.candidate);
   assign nm1      = n_ff - W'(1);
   assign csr.ready = 1'b1;
   assign csr_seed  = csr.valid && (csr.index == mrpt_pkg::REG_WITNESS_SEED);
   assign req.ready = (state_ff == mrpt_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.is_prime = prime_ff;

   mrpt_lfsr u_lfsr (
      .clock (clock),
      .reset (reset),
      .load  (csr_seed),
      .seed  (csr.data),
      .step  (lfsr_step),
      .value (lfsr_value)
   );

   mrpt_modmul #(.WIDTH(W)) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .op_a    (op_a),
      .op_b    (op_b),
      .modulus (op_m),
      .status  (status),
      .result  (unit_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mrpt_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         round_count_ff <= mrpt_pkg::ROUND_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.index == mrpt_pkg::REG_ROUND_COUNT) begin
            round_count_ff <= csr.data[mrpt_pkg::ROUND_WIDTH-1:0];
         end
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      e_ff       <= e_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      sq_e_ff    <= sq_e_in;
      rounds_ff  <= rounds_in;
      prime_ff   <= prime_in;
      pow_mul_ff <= pow_mul_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      n_in = n_ff; d_in = d_ff; e_in = e_ff; base_in = base_ff;
      acc_in = acc_ff; sq_e_in = sq_e_ff; rounds_in = rounds_ff;
      prime_in = prime_ff; pow_mul_in = pow_mul_ff;
      lfsr_step = 1'b0;
      cmd.start = 1'b0;
      cmd.op    = mrpt_pkg::OP_NONE;
      op_a = acc_ff; op_b = base_ff; op_m = n_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         mrpt_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               n_in = cand_ext;
               if (cand_ext <= W'(1) || cand_ext == W'(4) || (cand_ext > W'(3) && !cand_ext[0])) begin
                  prime_in = 1'b0;
                  state_in = mrpt_pkg::ST_DONE;
               end else if (cand_ext <= W'(3)) begin
                  prime_in = 1'b1;
                  state_in = mrpt_pkg::ST_DONE;
               end else begin
                  d_in      = cand_ext - W'(1);
                  prime_in  = 1'b1;
                  rounds_in = '0;
                  state_in  = mrpt_pkg::ST_SPLIT;
               end
            end
         end
         mrpt_pkg::ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
            end else if (rounds_ff == round_count_ff) begin
               state_in = mrpt_pkg::ST_DONE;
            end else begin
               state_in = mrpt_pkg::ST_DRAW;
            end
         end
         mrpt_pkg::ST_DRAW: begin
            lfsr_step = 1'b1;
            state_in  = mrpt_pkg::ST_REDUCE;
         end
         mrpt_pkg::ST_REDUCE: begin
            // r mod (n-4), witness base ready when done
            op_a = W'(lfsr_value);
            op_m = n_ff - W'(4);
            if (!status.busy && !status.done) begin
               cmd.start = 1'b1;
               cmd.op    = mrpt_pkg::OP_MOD;
            end
            if (status.done) begin
               base_in    = unit_result + W'(2);
               acc_in     = W'(1);
               e_in       = d_ff;
               pow_mul_in = 1'b0;
               state_in   = mrpt_pkg::ST_POW_MUL;
            end
         end
         mrpt_pkg::ST_POW_MUL: begin
            if (e_ff == '0) begin
               state_in = mrpt_pkg::ST_CHECK;
            end else if (!e_ff[0]) begin
               state_in = mrpt_pkg::ST_POW_SQR;
            end else begin
               op_a = acc_ff; op_b = base_ff;
               if (!status.busy && !status.done && !pow_mul_ff) begin
                  cmd.start  = 1'b1;
                  cmd.op     = mrpt_pkg::OP_MULMOD;
                  pow_mul_in = 1'b1;
               end
               if (status.done) begin
                  acc_in     = unit_result;
                  pow_mul_in = 1'b0;
                  state_in   = mrpt_pkg::ST_POW_SQR;
               end
            end
         end
         mrpt_pkg::ST_POW_SQR: begin
            op_a = base_ff; op_b = base_ff;
            if (!status.busy && !status.done && !pow_mul_ff) begin
               cmd.start  = 1'b1;
               cmd.op     = mrpt_pkg::OP_MULMOD;
               pow_mul_in = 1'b1;
            end
            if (status.done) begin
               base_in    = unit_result;
               e_in       = e_ff >> 1;
               pow_mul_in = 1'b0;
               state_in   = mrpt_pkg::ST_POW_MUL;
            end
         end
         mrpt_pkg::ST_CHECK: begin
            sq_e_in = d_ff;
            if (acc_ff == W'(1) || acc_ff == nm1) begin
               rounds_in = rounds_ff + 1'b1;
               state_in  = mrpt_pkg::ST_SPLIT;
            end else begin
               state_in = mrpt_pkg::ST_SQUARE;
            end
         end
         mrpt_pkg::ST_SQUARE: begin
            op_a = acc_ff; op_b = acc_ff;
            if (sq_e_ff == nm1) begin
               prime_in = 1'b0;
               state_in = mrpt_pkg::ST_DONE;
            end else begin
               if (!status.busy && !status.done && !pow_mul_ff) begin
                  cmd.start  = 1'b1;
                  cmd.op     = mrpt_pkg::OP_MULMOD;
                  pow_mul_in = 1'b1;
               end
               if (status.done) begin
                  acc_in     = unit_result;
                  sq_e_in    = sq_e_ff << 1;
                  pow_mul_in = 1'b0;
                  state_in   = mrpt_pkg::ST_SQUARE_CHECK;
               end
            end
         end
         mrpt_pkg::ST_SQUARE_CHECK: begin
            if (acc_ff == W'(1)) begin
               prime_in = 1'b0;
               state_in = mrpt_pkg::ST_DONE;
            end else if (acc_ff == nm1) begin
               rounds_in = rounds_ff + 1'b1;
               state_in  = mrpt_pkg::ST_SPLIT;
            end else begin
               state_in = mrpt_pkg::ST_SQUARE;
            end
         end
         mrpt_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = mrpt_pkg::ST_IDLE;
         end
         default: begin
            state_in = mrpt_pkg::ST_IDLE;
         end
      endcase
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.is_prime))
      else $error("response dropped while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != mrpt_pkg::ST_IDLE |-> !req.ready)
      else $error("request accepted while busy");

   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !status.busy)
      else $error("modular unit started while busy");

endmodule

// ===== hdl/mrpt_modmul.sv =====
// ----------------------------------------------------------------------------
// mrpt_modmul
// shared modular unit: (a*b) mod m or a mod m, one dividend bit per cycle
// ----------------------------------------------------------------------------
module mrpt_modmul #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mrpt_pkg::mod_cmd_type    cmd,
   input  logic [WIDTH-1:0]         op_a,
   input  logic [WIDTH-1:0]         op_b,
   input  logic [WIDTH-1:0]         modulus,
   output mrpt_pkg::mod_status_type status,
   output logic [WIDTH-1:0]         result
);

   localparam int unsigned PW = 2 * WIDTH;
   localparam int unsigned CW = $clog2(PW + 1);

   logic [PW-1:0]    dividend_ff, dividend_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] mod_ff, mod_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   mod_ext;

   assign mod_ext = {1'b0, mod_ff};

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      mod_in      = mod_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      shifted     = {rem_ff[WIDTH-1:0], dividend_ff[PW-1]};
      if (cmd.start && !busy_ff) begin
         mod_in   = modulus;
         rem_in   = '0;
         busy_in  = 1'b1;
         count_in = CW'(PW);
         if (cmd.op == mrpt_pkg::OP_MULMOD) begin
            dividend_in = op_a * op_b;
         end else begin
            dividend_in = {op_a, {WIDTH{1'b0}}};
            count_in    = CW'(WIDTH);
         end
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[PW-2:0], 1'b0};
         if (shifted >= mod_ext) begin
            rem_in = shifted - mod_ext;
         end else begin
            rem_in = shifted;
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      mod_ff      <= mod_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = rem_ff[WIDTH-1:0];

endmodule

// ===== hdl/mrpt_lfsr.sv =====
// ----------------------------------------------------------------------------
// mrpt_lfsr
// galois witness generator with seed reload
// ----------------------------------------------------------------------------
module mrpt_lfsr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [mrpt_pkg::SEED_WIDTH-1:0] seed,
   input  logic                            step,
   output logic [mrpt_pkg::SEED_WIDTH-1:0] value
);

   logic [mrpt_pkg::SEED_WIDTH-1:0] lfsr_ff, lfsr_in, shifted;

   always_comb begin
      shifted = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ mrpt_pkg::LFSR_TAPS) : (lfsr_ff >> 1);
      lfsr_in = lfsr_ff;
      if (load) begin
         lfsr_in = (seed != '0) ? seed : mrpt_pkg::SEED_WIDTH'(1);
      end else if (step) begin
         lfsr_in = (shifted != '0) ? shifted : mrpt_pkg::SEED_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= mrpt_pkg::WITNESS_SEED_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   assign value = lfsr_ff;

endmodule
